FILE: rtl/date_time_set_editor_unit_macros.svh
// Assertion macros for the date and time set editor unit.
`ifndef DATE_TIME_SET_EDITOR_UNIT_MACROS_SVH
`define DATE_TIME_SET_EDITOR_UNIT_MACROS_SVH

// Check that holds in the same cycle as the antecedent.
`define DTSE_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that holds in the cycle after the antecedent.
`define DTSE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/dtse_pkg.sv
// Package with key codes, field codes, the calendar state type and the month length function.
`default_nettype none

package dtse_pkg;

  localparam logic [7:0] KeyExit = 8'd1;
  localparam logic [7:0] KeyDec  = 8'd2;
  localparam logic [7:0] KeyInc  = 8'd3;
  localparam logic [7:0] KeySet  = 8'd4;

  localparam logic [2:0] FieldYear    = 3'd0;
  localparam logic [2:0] FieldDay     = 3'd1;
  localparam logic [2:0] FieldMonth   = 3'd2;
  localparam logic [2:0] FieldHour    = 3'd3;
  localparam logic [2:0] FieldMinute  = 3'd4;
  localparam logic [2:0] FieldSecond  = 3'd5;
  localparam logic [2:0] FieldWeekday = 3'd6;

  // The century never changes, so only the two low digits are stored.
  localparam int ResetYear   = 2018;
  localparam int YearCentury = ResetYear / 100;
  localparam logic [13:0] YearBase = 14'(YearCentury * 100);
  localparam logic CenturyLeap = ((YearCentury % 4) == 0);

  typedef struct packed {
    logic [6:0] year_lo;
    logic [3:0] month;
    logic [4:0] day;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [2:0] weekday;
    logic [2:0] sel;
  } cal_t;

  localparam cal_t CalReset = '{
    year_lo: 7'(ResetYear % 100),
    month:   4'd6,
    day:     5'd25,
    hour:    5'd8,
    minute:  6'd27,
    second:  6'd40,
    weekday: 3'd1,
    sel:     FieldYear
  };

  // Gregorian month length. Since 100 is a multiple of 4, divisibility by 4
  // follows from the low digits; a year ending in 00 is leap only when the
  // century is a multiple of 4.
  function automatic logic [4:0] month_len(input logic [6:0] year_lo,
                                           input logic [3:0] month);
    logic leap;
    logic [4:0] len;
    leap = (year_lo[1:0] == 2'd0) && ((year_lo != 7'd0) || CenturyLeap);
    case (month) inside
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      4'd2:                    len = leap ? 5'd29 : 5'd28;
      default:                 len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/dtse_key_reg.sv
// Input register that holds one key code until the editor takes it.
`default_nettype none

module dtse_key_reg
  import dtse_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] key_code,
  input  logic       take,
  output logic       key_valid,
  output logic [7:0] key_q
);

  // A held key blocks the port until the editor takes it.
  assign in_stall = key_valid && !take;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_valid <= 1'b0;
    end else if (!in_stall) begin
      key_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      key_q <= key_code;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/dtse_edit_logic.sv
// Next-state logic that applies one key to the calendar state.
`default_nettype none

module dtse_edit_logic
  import dtse_pkg::*;
(
  input  logic [7:0] key,
  input  cal_t       cal,
  output cal_t       cal_next,
  output logic       done
);

  // Step a value up or down, wrapping within lo..hi.
  function automatic logic [6:0] wrap(input logic [6:0] v, input logic [6:0] lo,
                                      input logic [6:0] hi, input logic up);
    logic [6:0] r;
    if (up) begin
      r = ((v + 7'd1) > hi) ? lo : (v + 7'd1);
    end else begin
      r = (v <= lo) ? hi : (v - 7'd1);
    end
    return r;
  endfunction

  logic       adj;
  logic       up;
  logic [4:0] days;

  assign days = month_len(cal.year_lo, cal.month);
  assign adj  = (key == KeyInc) || (key == KeyDec);
  assign up   = (key == KeyInc);

  always_comb begin
    cal_next = cal;
    done     = 1'b0;
    unique case (key)
      KeySet: begin
        cal_next.sel = (cal.sel >= FieldWeekday) ? FieldYear : (cal.sel + 3'd1);
      end
      KeyExit: begin
        cal_next.sel = FieldYear;
        done         = 1'b1;
      end
      default: begin
      end
    endcase
    if (adj) begin
      unique case (cal.sel)
        FieldYear:    cal_next.year_lo = wrap(cal.year_lo, 7'd0, 7'd99, up);
        FieldDay:     cal_next.day     = 5'(wrap({2'd0, cal.day}, 7'd1,
                                                 {2'd0, days}, up));
        FieldMonth:   cal_next.month   = 4'(wrap({3'd0, cal.month}, 7'd1, 7'd12, up));
        FieldHour:    cal_next.hour    = 5'(wrap({2'd0, cal.hour}, 7'd0, 7'd23, up));
        FieldMinute:  cal_next.minute  = 6'(wrap({1'b0, cal.minute}, 7'd0, 7'd59, up));
        FieldSecond:  cal_next.second  = 6'(wrap({1'b0, cal.second}, 7'd0, 7'd59, up));
        FieldWeekday: cal_next.weekday = 3'(wrap({4'd0, cal.weekday}, 7'd1, 7'd7, up));
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/date_time_set_editor_unit.sv
// A key moves from the input register to the result register when that register is empty or its transfer completes.
// Throughput: one key per cycle while out_stall is low; the calendar state updates in the same cycle as the result.
// The combinational path between the registers is the field wrap logic and the month length lookup.
// Reset (rst, synchronous): calendar returns to 2018-06-25 08:27:40, weekday 1, year selected.
// Reset also empties the input and result registers.
`default_nettype none

module date_time_set_editor_unit
  import dtse_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  key_code,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [13:0] year,
  output logic [3:0]  month,
  output logic [4:0]  day,
  output logic [4:0]  hour,
  output logic [5:0]  minute,
  output logic [5:0]  second,
  output logic [2:0]  weekday,
  output logic [2:0]  selected_field,
  output logic        done_res
);

`include "date_time_set_editor_unit_macros.svh"

  logic       key_valid;
  logic [7:0] key_q;
  logic       advance;
  cal_t       cal;
  cal_t       cal_next;
  logic       done_next;

  // A held key moves on whenever the result register is empty or its
  // transfer completes this cycle, so keys stream at one per cycle.
  assign advance = key_valid && (!out_valid || !out_stall);

  dtse_key_reg u_key_reg (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .key_code  (key_code),
    .take      (advance),
    .key_valid (key_valid),
    .key_q     (key_q)
  );

  dtse_edit_logic u_edit_logic (
    .key      (key_q),
    .cal      (cal),
    .cal_next (cal_next),
    .done     (done_next)
  );

  // Calendar state and the result valid flag. The state changes exactly
  // when a key reaches the result register, so the next key always sees
  // the effect of the one before it.
  always_ff @(posedge clk) begin
    if (rst) begin
      cal       <= CalReset;
      out_valid <= 1'b0;
    end else if (advance) begin
      cal       <= cal_next;
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload. The full year is rebuilt from the fixed century and
  // the stored two low digits.
  always_ff @(posedge clk) begin
    if (advance) begin
      year           <= YearBase + {7'd0, cal_next.year_lo};
      month          <= cal_next.month;
      day            <= cal_next.day;
      hour           <= cal_next.hour;
      minute         <= cal_next.minute;
      second         <= cal_next.second;
      weekday        <= cal_next.weekday;
      selected_field <= cal_next.sel;
      done_res       <= done_next;
    end
  end

  // The selection counter never leaves the seven fields.
  `DTSE_ASSERT_SAME(a_sel_range, 1'b1, cal.sel <= FieldWeekday, "field selection out of range")
  // An exit result always comes with the year selected.
  `DTSE_ASSERT_SAME(a_exit_sel, out_valid && done_res, selected_field == FieldYear,
    "exit result without year selected")
  // Day and month never reach zero.
  `DTSE_ASSERT_SAME(a_day_month, 1'b1, (cal.day != 5'd0) && (cal.month != 4'd0),
    "day or month is zero")
  // A key that cannot move on stays held in the input register.
  `DTSE_ASSERT_NEXT(a_key_hold, key_valid && !advance, key_valid && $stable(key_q),
    "held key lost")
  // The result shown matches the stored state right after a key moves on.
  `DTSE_ASSERT_NEXT(a_out_state, advance, (selected_field == cal.sel) && (day == cal.day),
    "result differs from stored state")

endmodule

`default_nettype wire
